// ===== rtl/utf16_to_utf8_encoder_unit_assert.svh =====
// Assertion macros for the UTF-16 to UTF-8 encoder unit
`ifndef UTF16_TO_UTF8_ENCODER_UNIT_ASSERT_SVH
`define UTF16_TO_UTF8_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define U2U8_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U2U8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/u2u8_pkg.sv =====
// Shared types, constants and helpers of the UTF-16 to UTF-8 encoder
package u2u8_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int UNIT_W = 16;
  localparam int CAP_W  = 16;
  localparam int POS_W  = 24;

  localparam logic [CAP_W-1:0]  CAP_RESET    = 16'd260;
  localparam logic [UNIT_W-1:0] ONE_BYTE_LIM = 16'h0080;
  localparam logic [UNIT_W-1:0] TWO_BYTE_LIM = 16'h0800;
  localparam logic [UNIT_W-1:0] HI_MIN       = 16'hD800;
  localparam logic [UNIT_W-1:0] HI_MAX       = 16'hDBFF;
  localparam logic [UNIT_W-1:0] LO_MIN       = 16'hDC00;
  localparam logic [UNIT_W-1:0] LO_MAX       = 16'hDFFF;
  localparam logic [20:0]       SUPP_BASE    = 21'h10000;

  localparam logic ACT_UNIT = 1'b0;
  localparam logic ACT_END  = 1'b1;

  typedef enum logic [1:0] {
    MAIN_NONE,
    MAIN_CHAR,
    MAIN_TERM
  } main_kind_t;

  typedef struct packed {
    logic            fl_valid;
    logic [2:0][7:0] fl_bytes;
    main_kind_t      kind;
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic             stored;
    logic             term;
    logic [POS_W-1:0] total;
    logic             last;
  } res_t;

  function automatic logic [2:0][7:0] enc3(input logic [UNIT_W-1:0] u);
    logic [2:0][7:0] r;
    r[0] = {4'hE, u[15:12]};
    r[1] = {2'b10, u[11:6]};
    r[2] = {2'b10, u[5:0]};
    return r;
  endfunction

endpackage

// ===== rtl/u2u8_fifo.sv =====
// Short register queue between the front and back parts
module u2u8_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/u2u8_front.sv =====
// Front part: accept code units, pair surrogates, encode into byte jobs
module u2u8_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_action,
  input  logic [u2u8_pkg::UNIT_W-1:0] in_code_unit,
  output logic                       push,
  output u2u8_pkg::job_t             job
);
  import u2u8_pkg::*;

  logic            held_valid_r, held_valid_nxt;
  logic [9:0]      held_r, held_nxt;
  logic            accept;
  logic            is_end, is_hi, is_lo, pair;
  logic [20:0]     supp;
  logic [2:0][7:0] b3;

  assign accept = in_valid && !in_stall;
  assign is_end = (in_action == ACT_END);
  assign is_hi  = in_code_unit inside {[HI_MIN:HI_MAX]};
  assign is_lo  = in_code_unit inside {[LO_MIN:LO_MAX]};
  assign pair   = !is_end && held_valid_r && is_lo;
  assign supp   = SUPP_BASE + {1'b0, held_r, in_code_unit[9:0]};
  assign b3     = enc3(in_code_unit);

  always_comb begin
    job          = '0;
    job.fl_valid = held_valid_r && !pair;
    job.fl_bytes = enc3(HI_MIN | {6'b0, held_r});
    job.kind     = MAIN_CHAR;
    held_valid_nxt = held_valid_r;
    held_nxt       = held_r;
    if (accept) begin
      held_valid_nxt = 1'b0;
      held_nxt       = '0;
    end
    if (is_end) begin
      job.kind = MAIN_TERM;
    end else if (pair) begin
      job.len      = 3'd4;
      job.bytes[0] = {5'b11110, supp[20:18]};
      job.bytes[1] = {2'b10, supp[17:12]};
      job.bytes[2] = {2'b10, supp[11:6]};
      job.bytes[3] = {2'b10, supp[5:0]};
    end else if (in_code_unit < ONE_BYTE_LIM) begin
      job.len      = 3'd1;
      job.bytes[0] = in_code_unit[7:0];
    end else if (in_code_unit < TWO_BYTE_LIM) begin
      job.len      = 3'd2;
      job.bytes[0] = {3'b110, in_code_unit[10:6]};
      job.bytes[1] = {2'b10, in_code_unit[5:0]};
    end else if (is_hi) begin
      job.kind = MAIN_NONE;
      if (accept) begin
        held_valid_nxt = 1'b1;
        held_nxt       = in_code_unit[9:0];
      end
    end else begin
      job.len      = 3'd3;
      job.bytes[0] = b3[0];
      job.bytes[1] = b3[1];
      job.bytes[2] = b3[2];
    end
    push = accept && (job.fl_valid || (job.kind != MAIN_NONE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_r       <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_r       <= held_nxt;
    end
  end

endmodule

// ===== rtl/u2u8_back.sv =====
// Back part: emit job bytes one per cycle unless stalled or empty, count, test fit, hold result
module u2u8_back #(
  parameter int COUNT_WIDTH = u2u8_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [u2u8_pkg::CAP_W-1:0] capacity,
  input  u2u8_pkg::job_t             job,
  input  logic                       empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output u2u8_pkg::res_t             res
);
  import u2u8_pkg::*;

  localparam int FW = COUNT_WIDTH + CAP_W + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] term_r, term_nxt;
  logic                   trunc_r, trunc_nxt;
  logic                   fits_r, fits_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic                   fl_done_r, fl_done_nxt;
  logic                   out_valid_r, out_valid_nxt;
  res_t                   res_r, res_nxt;

  logic                   cur_fl, cur_term, char_end, job_end;
  logic                   fit_now, stored_byte, fire;
  logic [2:0]             cur_n;
  logic [7:0]             cur_byte;
  logic [COUNT_WIDTH-1:0] tpos;
  logic [COUNT_WIDTH+POS_W-1:0] cnt_ext, tpos_ext;

  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    cur_fl   = job.fl_valid && !fl_done_r;
    cur_n    = cur_fl ? 3'd3 : job.len;
    cur_term = !cur_fl && (job.kind == MAIN_TERM);
    cur_byte = cur_fl ? job.fl_bytes[idx_r] : job.bytes[idx_r];
    char_end = ({1'b0, idx_r} == (cur_n - 3'd1));
    job_end  = cur_term || (char_end && (!cur_fl || (job.kind == MAIN_NONE)));
    fit_now  = !trunc_r && ((FW'(cnt_r) + FW'(cur_n)) < FW'(capacity));
    stored_byte = (idx_r == 2'd0) ? fit_now : fits_r;
    tpos     = trunc_r ? term_r : cnt_r;
    cnt_ext  = {{POS_W{1'b0}}, cnt_r};
    tpos_ext = {{POS_W{1'b0}}, tpos};
    fire     = (!out_valid_r || !out_stall) && !empty;
    pop      = fire && job_end;

    cnt_nxt       = cnt_r;
    term_nxt      = term_r;
    trunc_nxt     = trunc_r;
    fits_nxt      = fits_r;
    idx_nxt       = idx_r;
    fl_done_nxt   = fl_done_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (fire) begin
      out_valid_nxt = 1'b1;
      if (cur_term) begin
        res_nxt.data   = 8'h00;
        res_nxt.pos    = tpos_ext[POS_W-1:0];
        res_nxt.stored = (FW'(tpos) < FW'(capacity));
        res_nxt.term   = 1'b1;
        res_nxt.total  = cnt_ext[POS_W-1:0];
        res_nxt.last   = 1'b1;
        cnt_nxt   = '0;
        term_nxt  = '0;
        trunc_nxt = 1'b0;
      end else begin
        res_nxt.data   = cur_byte;
        res_nxt.pos    = cnt_ext[POS_W-1:0];
        res_nxt.stored = stored_byte;
        res_nxt.term   = 1'b0;
        res_nxt.total  = '0;
        res_nxt.last   = job_end;
        if (idx_r == 2'd0) begin
          fits_nxt = fit_now;
          if (!fit_now && !trunc_r) begin
            trunc_nxt = 1'b1;
            term_nxt  = cnt_r;
          end
        end
        cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + COUNT_WIDTH'(1);
      end
      if (job_end) begin
        idx_nxt     = '0;
        fl_done_nxt = 1'b0;
      end else if (char_end) begin
        idx_nxt     = '0;
        fl_done_nxt = fl_done_r || cur_fl;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      term_r      <= '0;
      trunc_r     <= 1'b0;
      fits_r      <= 1'b0;
      idx_r       <= '0;
      fl_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      term_r      <= term_nxt;
      trunc_r     <= trunc_nxt;
      fits_r      <= fits_nxt;
      idx_r       <= idx_nxt;
      fl_done_r   <= fl_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// ===== rtl/utf16_to_utf8_encoder_unit.sv =====
// Top level of the UTF-16 to UTF-8 encoder: front, job queue, back, config
//
//   channel  direction  handshake          word
//   in_      input      in_valid/in_stall  action + 16-bit code unit
//   out_     output     out_valid/out_stall one UTF-8 byte or terminator
//   cfg_     input      cfg_valid/cfg_ready 16-bit destination capacity
//
// The front takes one word per cycle while the job queue has room.
// The back emits one result per cycle while out_stall is low and a job
// waits; a word causes 0 to 6 results, made by the back's sequencer.
// Reset is synchronous and active low; capacity returns to 260.
// A stalled output holds its result; the queue keeps the input side moving until full.
`include "utf16_to_utf8_encoder_unit_assert.svh"

module utf16_to_utf8_encoder_unit #(
  parameter int COUNT_WIDTH = u2u8_pkg::COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = u2u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [u2u8_pkg::UNIT_W-1:0] in_code_unit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic [u2u8_pkg::POS_W-1:0]  out_byte_position,
  output logic                        out_stored,
  output logic                        out_is_terminator,
  output logic [u2u8_pkg::POS_W-1:0]  out_total_length,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [u2u8_pkg::CAP_W-1:0]  cfg_data
);
  import u2u8_pkg::*;

  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             push, pop, full, empty;
  job_t             job_in, job_out;
  logic [JOB_W-1:0] job_out_bits;
  res_t             res;

  assign cfg_ready = rst_n;
  assign cap_nxt   = (cfg_valid && cfg_ready) ? cfg_data : cap_r;
  assign in_stall  = full || !rst_n;
  assign job_out   = job_t'(job_out_bits);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  u2u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_code_unit (in_code_unit),
    .push         (push),
    .job          (job_in)
  );

  u2u8_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (job_in),
    .full  (full),
    .pop   (pop),
    .dout  (job_out_bits),
    .empty (empty)
  );

  u2u8_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (cap_r),
    .job       (job_out),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_byte          = res.data;
  assign out_byte_position = res.pos;
  assign out_stored        = res.stored;
  assign out_is_terminator = res.term;
  assign out_total_length  = res.total;
  assign out_last          = res.last;

  `U2U8_ASSERT_IMPL(a_term_is_last, out_valid && out_is_terminator, out_last && (out_byte == 8'h00), "terminator not last or not zero")
  `U2U8_ASSERT_NEXT(a_bytes_follow, out_valid && !out_stall && !out_last, out_valid, "gap inside a word's results")
  `U2U8_ASSERT_IMPL(a_queue_stall, full, !empty, "stall with empty queue")

endmodule

// ===== sim/tb_utf16_to_utf8_encoder_unit.sv =====
// Self-checking testbench for the UTF-16 to UTF-8 encoder unit
module tb_utf16_to_utf8_encoder_unit;
  import u2u8_pkg::*;

  localparam int RANDOM_WORDS = 400;
  localparam int PHASES       = 9;
  localparam int SETTLE       = 40;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SHOWN_FAULTS = 10;

  localparam int K_ASCII = 0;
  localparam int K_TWO   = 1;
  localparam int K_THREE = 2;
  localparam int K_HIGH  = 3;
  localparam int K_LOW   = 4;
  localparam int K_ANY   = 5;

  typedef struct packed {
    logic              action;
    logic [UNIT_W-1:0] code;
  } utf16_word_t;

  localparam int N_DIRECTED = 24;
  localparam logic [UNIT_W:0] DIRECTED [N_DIRECTED] = '{
    {ACT_UNIT, 16'h0000}, {ACT_UNIT, 16'h007F}, {ACT_UNIT, 16'h0080}, {ACT_UNIT, 16'h07FF},
    {ACT_UNIT, 16'h0800}, {ACT_UNIT, 16'hFFFF}, {ACT_UNIT, 16'hD800}, {ACT_UNIT, 16'hDC00},
    {ACT_UNIT, 16'hDBFF}, {ACT_UNIT, 16'hDFFF}, {ACT_UNIT, 16'hDFFF}, {ACT_UNIT, 16'hDBFF},
    {ACT_UNIT, 16'h0041}, {ACT_UNIT, 16'hD800}, {ACT_UNIT, 16'hD9AB}, {ACT_UNIT, 16'hDC01},
    {ACT_UNIT, 16'hD812}, {ACT_UNIT, 16'hE000}, {ACT_UNIT, 16'hD7FF}, {ACT_UNIT, 16'hDB00},
    {ACT_END,  16'hFFFF}, {ACT_END,  16'h0000}, {ACT_UNIT, 16'hDA55}, {ACT_END,  16'h5A5A}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_action = 1'b0;
  logic [UNIT_W-1:0]    in_code_unit = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte;
  logic [POS_W-1:0]     out_byte_position;
  logic                 out_stored;
  logic                 out_is_terminator;
  logic [POS_W-1:0]     out_total_length;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CAP_W-1:0]     cfg_data = '0;

  utf16_word_t pending_words[$];
  res_t        expected_bytes[$];

  // encoder state as predicted
  logic [CAP_W-1:0] capacity_reg = CAP_RESET;
  logic [9:0]       enc_held_bits = '0;
  logic             enc_held = 1'b0;
  logic [POS_W-1:0] enc_count = '0;
  logic             enc_cut = 1'b0;
  logic [POS_W-1:0] enc_term_pos = '0;

  int   send_idle_pct = 13;
  int   recv_idle_pct = 56;
  bit   word_taken = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;
  int   words_accepted = 0;
  int   results_checked = 0;
  int   fault_count = 0;
  int   settings_used = 0;
  int   cycle_count = 0;

  utf16_to_utf8_encoder_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_code_unit      (in_code_unit),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_byte_position (out_byte_position),
    .out_stored        (out_stored),
    .out_is_terminator (out_is_terminator),
    .out_total_length  (out_total_length),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [POS_W-1:0] sat_count(input logic [POS_W-1:0] a, input int b);
    longint s;
    s = longint'(a) + b;
    return (s > longint'({POS_W{1'b1}})) ? {POS_W{1'b1}} : s[POS_W-1:0];
  endfunction

  task automatic emit_utf8(input logic [7:0] seq [4], input int n, inout int made);
    logic fits;
    res_t r;
    fits = !enc_cut && (longint'(enc_count) + n < longint'(capacity_reg));
    if (!fits && !enc_cut) begin
      enc_cut = 1'b1;
      enc_term_pos = enc_count;
    end
    for (int j = 0; j < n; j++) begin
      r.data   = seq[j];
      r.pos    = sat_count(enc_count, j);
      r.stored = fits;
      r.term   = 1'b0;
      r.total  = '0;
      r.last   = 1'b0;
      expected_bytes.push_back(r);
    end
    enc_count = sat_count(enc_count, n);
    made += n;
  endtask

  task automatic emit_three_bytes(input logic [UNIT_W-1:0] code, inout int made);
    logic [7:0] seq [4];
    seq[0] = {4'hE, code[15:12]};
    seq[1] = {2'b10, code[11:6]};
    seq[2] = {2'b10, code[5:0]};
    seq[3] = 8'h00;
    emit_utf8(seq, 3, made);
  endtask

  task automatic predict_utf8(input utf16_word_t w);
    logic [7:0]       seq [4];
    logic [20:0]      cp;
    logic [POS_W-1:0] tpos;
    res_t             r;
    int               made;
    made = 0;
    seq = '{default: 8'h00};
    if (w.action == ACT_END) begin
      if (enc_held) begin
        emit_three_bytes({6'b110110, enc_held_bits}, made);
        enc_held = 1'b0;
        enc_held_bits = '0;
      end
      tpos = enc_cut ? enc_term_pos : enc_count;
      r.data   = 8'h00;
      r.pos    = tpos;
      r.stored = (longint'(tpos) < longint'(capacity_reg));
      r.term   = 1'b1;
      r.total  = enc_count;
      r.last   = 1'b0;
      expected_bytes.push_back(r);
      made++;
      enc_count = '0;
      enc_cut = 1'b0;
      enc_term_pos = '0;
    end else if (enc_held && w.code >= LO_MIN && w.code <= LO_MAX) begin
      cp = SUPP_BASE + {enc_held_bits, w.code[9:0]};
      seq[0] = {5'b11110, cp[20:18]};
      seq[1] = {2'b10, cp[17:12]};
      seq[2] = {2'b10, cp[11:6]};
      seq[3] = {2'b10, cp[5:0]};
      enc_held = 1'b0;
      enc_held_bits = '0;
      emit_utf8(seq, 4, made);
    end else begin
      if (enc_held) begin
        emit_three_bytes({6'b110110, enc_held_bits}, made);
        enc_held = 1'b0;
        enc_held_bits = '0;
      end
      if (w.code < ONE_BYTE_LIM) begin
        seq[0] = w.code[7:0];
        emit_utf8(seq, 1, made);
      end else if (w.code < TWO_BYTE_LIM) begin
        seq[0] = {3'b110, w.code[10:6]};
        seq[1] = {2'b10, w.code[5:0]};
        emit_utf8(seq, 2, made);
      end else if (w.code >= HI_MIN && w.code <= HI_MAX) begin
        enc_held = 1'b1;
        enc_held_bits = w.code[9:0];
      end else begin
        emit_three_bytes(w.code, made);
      end
    end
    if (made > 0) begin
      r = expected_bytes.pop_back();
      r.last = 1'b1;
      expected_bytes.push_back(r);
    end
  endtask

  function automatic logic [UNIT_W-1:0] code_of_kind(input int kind);
    int v;
    case (kind)
      K_ASCII: v = $urandom_range(16'h0000, 16'h007F);
      K_TWO:   v = $urandom_range(16'h0080, 16'h07FF);
      K_THREE: begin
        v = $urandom_range(16'h0800, 16'hF7FF);
        if (v >= HI_MIN) v += 16'h0800;
      end
      K_HIGH:  v = $urandom_range(HI_MIN, HI_MAX);
      K_LOW:   v = $urandom_range(LO_MIN, LO_MAX);
      default: v = $urandom_range(0, 16'hFFFF);
    endcase
    return v[UNIT_W-1:0];
  endfunction

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= SHOWN_FAULTS) $display("[%0t] %s", $time, msg);
  endtask

  task automatic drain_and_settle();
    while (pending_words.size() != 0 || expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // driver: present the oldest pending word, hold it while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid     <= 1'b1;
        in_action    <= pending_words[0].action;
        in_code_unit <= pending_words[0].code;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && words_accepted >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // monitor: predict on accepted words, check accepted results
  always @(posedge clk) begin
    utf16_word_t w;
    res_t        got;
    res_t        want;
    word_taken = rst_n && in_valid && !in_stall;
    if (word_taken) begin
      w = pending_words.pop_front();
      predict_utf8(w);
      words_accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_byte, out_byte_position, out_stored, out_is_terminator,
              out_total_length, out_last};
      if (expected_bytes.size() == 0) begin
        report_fault($sformatf("unexpected result byte=%h pos=%0d term=%b",
                               got.data, got.pos, got.term));
      end else begin
        want = expected_bytes.pop_front();
        results_checked++;
        if (got !== want) begin
          report_fault($sformatf(
            "mismatch exp byte=%h pos=%0d st=%b term=%b tot=%0d last=%b | got byte=%h pos=%0d st=%b term=%b tot=%0d last=%b",
            want.data, want.pos, want.stored, want.term, want.total, want.last,
            got.data, got.pos, got.stored, got.term, got.total, got.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int per_phase;
    int queued;
    int nchars;
    int kind;
    logic [CAP_W-1:0] cap;
    per_phase = RANDOM_WORDS / PHASES;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) pending_words.push_back(utf16_word_t'(DIRECTED[i]));
    settings_used = 1;
    drain_and_settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       cap = 16'd0;
        1:       cap = 16'hFFFF;
        2:       cap = 16'd1;
        3:       cap = 16'd2;
        4:       cap = CAP_W'($urandom_range(3, 9));
        5:       cap = CAP_W'($urandom_range(10, 40));
        6:       cap = CAP_W'($urandom_range(0, 60));
        7:       cap = 16'd4;
        default: cap = CAP_W'($urandom_range(0, 16'hFFFF));
      endcase
      send_idle_pct = (p < 3) ? 13 : (p < 6) ? 56 : 0;
      recv_idle_pct = (p < 3) ? 56 : (p < 6) ? 13 : 0;

      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= cap;
      do @(posedge clk); while (!cfg_ready);
      capacity_reg = cap;
      settings_used++;
      @(negedge clk);
      cfg_valid <= 1'b0;

      queued = 0;
      while (queued < per_phase) begin
        if ($urandom_range(0, 99) < 80) begin
          // well-formed string, then end
          nchars = $urandom_range(0, 14);
          for (int c = 0; c < nchars; c++) begin
            kind = $urandom_range(K_ASCII, K_HIGH);
            if (kind == K_HIGH) begin
              pending_words.push_back('{ACT_UNIT, code_of_kind(K_HIGH)});
              pending_words.push_back('{ACT_UNIT, code_of_kind(K_LOW)});
              queued += 2;
            end else begin
              pending_words.push_back('{ACT_UNIT, code_of_kind(kind)});
              queued++;
            end
          end
        end else begin
          // noise: stray surrogates and arbitrary units
          nchars = $urandom_range(1, 8);
          for (int c = 0; c < nchars; c++) begin
            kind = $urandom_range(K_HIGH, K_ANY);
            pending_words.push_back('{ACT_UNIT, code_of_kind(kind)});
            queued++;
          end
          if ($urandom_range(0, 1) == 0) continue;
        end
        pending_words.push_back('{ACT_END, code_of_kind(K_ANY)});
        queued++;
      end
      drain_and_settle();
    end

    $display("Run covered %0d UTF-16 words over %0d capacity settings,", words_accepted,
             settings_used);
    $display("with %0d UTF-8 results checked and %0d faults found.", results_checked,
             fault_count);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/u2u8_pkg.sv
rtl/u2u8_fifo.sv
rtl/u2u8_front.sv
rtl/u2u8_back.sv
rtl/utf16_to_utf8_encoder_unit.sv
sim/tb_utf16_to_utf8_encoder_unit.sv
